### sv/psrs_pkg.sv
package psrs_pkg;

    localparam int unsigned CMD_W    = 8;
    localparam int unsigned PERIOD_W = 11;
    localparam int unsigned CFG_W    = 11;
    localparam int unsigned PHASE_W  = 10;
    localparam int unsigned TIME_W   = 64;
    localparam int unsigned RAW_W    = 24;
    localparam int unsigned PRES_W   = 22;
    localparam int unsigned TEMP_W   = 17;
    localparam int unsigned DELAY_W  = 63;
    localparam int unsigned IDX_W    = 3;
    localparam int unsigned STORE_N  = 6;
    localparam int unsigned S_DATA_W = 80;
    localparam int unsigned M_DATA_W = 240;

    localparam logic [CMD_W-1:0]    COMMAND_RESET = 8'd170;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET  = 11'd100;
    localparam logic [PERIOD_W-1:0] PHASE_MAX     = 11'd1024;
    localparam logic [7:0]          STATUS_OK     = 8'h40;
    localparam logic [IDX_W-1:0]    LAST_INDEX    = 3'd6;

    localparam logic [12:0]         P_SCALE  = 13'd6250;
    localparam logic [PRES_W-1:0]   P_OFFSET = 22'd160000;
    localparam logic [6:0]          T_SCALE  = 7'd125;
    localparam logic [TEMP_W-1:0]   T_OFFSET = 17'd59686;

    typedef enum logic {
        CFG_COMMAND_BYTE = 1'b0,
        CFG_START_PERIOD = 1'b1
    } cfg_index_t;

    typedef enum logic {
        KIND_TICK = 1'b0,
        KIND_BYTE = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        ACT_START = 2'd0,
        ACT_READ  = 2'd1,
        ACT_MEAS  = 2'd2
    } action_t;

    typedef struct packed {
        action_t             action;
        logic [CMD_W-1:0]    command;
        logic [RAW_W-1:0]    praw;
        logic [RAW_W-1:0]    traw;
        logic [TIME_W-1:0]   ready_stamp;
        logic [TIME_W-1:0]   done_stamp;
        logic [DELAY_W-1:0]  group_delay;
    } psrs_req_t;

endpackage

### sv/pressure_sensor_readout_sequencer_top.sv
// two register stages; a result passes the request register, then the output register, before m_tvalid
// throughput: one request per cycle, stalls only when both pipeline registers are full
// the request register and the output register each sit behind a ready/valid stage
// reset: synchronous, active low; clears phase, ready level, times, byte index, valid flags
// reset loads command byte 170 and start period 100; frame bytes are not cleared
module pressure_sensor_readout_sequencer_top
    import psrs_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_DATA_W-1:0]  s_tdata,   // ready_level, rx_byte[7:0], now_us[63:0], zero pad
    input  logic                 s_tuser,   // kind
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_DATA_W-1:0]  m_tdata,   // command_out, pressure, temperature, ready_stamp,
                                            // done_stamp, group_delay, zero pad
    output logic [1:0]           m_tuser    // action
);

    logic      req_valid;
    logic      req_ready;
    psrs_req_t req;

    psrs_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .kind        (s_tuser),
        .ready_level (s_tdata[0]),
        .rx_byte     (s_tdata[8:1]),
        .now_us      (s_tdata[72:9]),
        .req_ready   (req_ready),
        .req_valid   (req_valid),
        .req         (req)
    );

    psrs_conv u_conv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

### sv/psrs_ctrl.sv
module psrs_ctrl
    import psrs_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic                 kind,
    input  logic                 ready_level,
    input  logic [7:0]           rx_byte,
    input  logic [TIME_W-1:0]    now_us,
    input  logic                 req_ready,
    output logic                 req_valid,
    output psrs_req_t            req
);

    logic [CMD_W-1:0]    command_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic [PHASE_W-1:0]  phase_reg, phase_next;
    logic                prev_ready_reg, prev_ready_next;
    logic [TIME_W-1:0]   launch_reg, launch_next;
    logic [TIME_W-1:0]   ready_time_reg, ready_time_next;
    logic [IDX_W-1:0]    index_reg, index_next;
    logic [7:0]          frame_reg [STORE_N];
    logic                req_valid_reg, req_valid_next;
    psrs_req_t           req_reg, req_next;

    logic                accept;
    logic                hit;
    logic [PERIOD_W-1:0] eff_period;
    logic [PERIOD_W-1:0] phase_inc;
    logic [TIME_W-1:0]   delay_full;

    assign s_tready  = !req_valid_reg || req_ready;
    assign accept    = s_tvalid && s_tready;
    assign req_valid = req_valid_reg;
    assign req       = req_reg;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            command_reg <= COMMAND_RESET;
            period_reg  <= PERIOD_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_COMMAND_BYTE: command_reg <= cfg_data[CMD_W-1:0];
                CFG_START_PERIOD: period_reg  <= cfg_data[PERIOD_W-1:0];
            endcase
        end
    end

    always_comb begin
        if (period_reg == '0) begin
            eff_period = PERIOD_W'(1);
        end else if (period_reg > PHASE_MAX) begin
            eff_period = PHASE_MAX;
        end else begin
            eff_period = period_reg;
        end
    end

    assign phase_inc  = {1'b0, phase_reg} + PERIOD_W'(1);
    assign delay_full = ready_time_reg - launch_reg;

    always_comb begin
        phase_next      = phase_reg;
        prev_ready_next = prev_ready_reg;
        launch_next     = launch_reg;
        ready_time_next = ready_time_reg;
        index_next      = index_reg;
        hit             = 1'b0;
        req_next        = '0;
        req_next.action = ACT_START;
        if (accept) begin
            unique case (kind_t'(kind))
                KIND_TICK: begin
                    if (phase_reg == '0) begin
                        launch_next      = now_us;
                        hit              = 1'b1;
                        req_next.action  = ACT_START;
                        req_next.command = command_reg;
                    end else if (!prev_ready_reg && ready_level) begin
                        ready_time_next  = now_us;
                        hit              = 1'b1;
                        req_next.action  = ACT_READ;
                    end
                    prev_ready_next = ready_level;
                    if (phase_inc >= eff_period) begin
                        phase_next = '0;
                    end else begin
                        phase_next = phase_inc[PHASE_W-1:0];
                    end
                end
                KIND_BYTE: begin
                    if (index_reg < LAST_INDEX) begin
                        index_next = index_reg + IDX_W'(1);
                    end else begin
                        index_next = '0;
                        if (frame_reg[0] == STATUS_OK) begin
                            hit                  = 1'b1;
                            req_next.action      = ACT_MEAS;
                            req_next.praw        = {frame_reg[1], frame_reg[2], frame_reg[3]};
                            req_next.traw        = {frame_reg[4], frame_reg[5], rx_byte};
                            req_next.ready_stamp = ready_time_reg;
                            req_next.done_stamp  = now_us;
                            req_next.group_delay = delay_full[TIME_W-1:1];
                        end
                    end
                end
            endcase
        end
    end

    always_comb begin
        if (accept) begin
            req_valid_next = hit;
        end else if (req_ready) begin
            req_valid_next = 1'b0;
        end else begin
            req_valid_next = req_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= '0;
            prev_ready_reg <= 1'b0;
            launch_reg     <= '0;
            ready_time_reg <= '0;
            index_reg      <= '0;
            req_valid_reg  <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            prev_ready_reg <= prev_ready_next;
            launch_reg     <= launch_next;
            ready_time_reg <= ready_time_next;
            index_reg      <= index_next;
            req_valid_reg  <= req_valid_next;
        end
    end

    // frame byte store
    always_ff @(posedge aclk) begin
        if (accept && kind_t'(kind) == KIND_BYTE && index_reg < LAST_INDEX) begin
            frame_reg[index_reg] <= rx_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg <= req_next;
        end
    end

endmodule

### sv/psrs_conv.sv
module psrs_conv
    import psrs_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  psrs_req_t            req,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_DATA_W-1:0]  m_tdata,
    output logic [1:0]           m_tuser
);

    logic                    out_valid_reg, out_valid_next;
    logic [M_DATA_W-1:0]     data_reg, data_next;
    logic [1:0]              user_reg;

    logic [36:0]             p_prod;
    logic [30:0]             t_prod;
    logic [PRES_W-1:0]       pressure;
    logic [TEMP_W-1:0]       temperature;
    logic                    is_meas;

    assign req_ready = !out_valid_reg || m_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = data_reg;
    assign m_tuser   = user_reg;

    // fixed-point scaling of the raw words
    assign p_prod      = {13'b0, req.praw} * {24'b0, P_SCALE};
    assign t_prod      = {7'b0, req.traw} * {24'b0, T_SCALE};
    assign is_meas     = req.action == ACT_MEAS;
    assign pressure    = is_meas ? ({1'b0, p_prod[36:16]} - P_OFFSET) : '0;
    assign temperature = is_meas ? ({2'b0, t_prod[30:16]} + T_OFFSET) : '0;

    assign data_next = {2'b0, req.group_delay, req.done_stamp, req.ready_stamp,
                        temperature, pressure, req.command};

    always_comb begin
        if (req_ready) begin
            out_valid_next = req_valid;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (req_ready && req_valid) begin
            data_reg <= data_next;
            user_reg <= req.action;
        end
    end

endmodule

### test/tb_pressure_sensor_readout_sequencer_top.sv
`timescale 1ns / 100ps

module tb_pressure_sensor_readout_sequencer_top;
    import psrs_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        action_t     action;
        logic [7:0]  command;
        logic [21:0] pressure;
        logic [16:0] temperature;
        logic [63:0] ready_stamp;
        logic [63:0] done_stamp;
        logic [62:0] group_delay;
    } meas_t;

    typedef struct {
        bit          is_cfg;
        cfg_index_t  reg_sel;
        logic [10:0] reg_val;
        kind_t       kind;
        logic        level;
        logic [7:0]  rx;
        logic [63:0] now_us;
        bit          typed;
        bit          has_res;
        meas_t       res;
    } dir_row_t;

    logic                aclk;
    logic                aresetn;
    logic                cfg_we;
    logic                cfg_index;
    logic [CFG_W-1:0]    cfg_data;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;   // ready_level, rx_byte[7:0], now_us[63:0], zero pad
    logic                s_tuser;   // kind
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;   // command_out, pressure, temperature, ready_stamp,
                                    // done_stamp, group_delay, zero pad
    logic [1:0]          m_tuser;   // action

    pressure_sensor_readout_sequencer_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // sequencer state mirrored by the testbench
    logic [7:0]  cmd_reg;
    logic [10:0] period_reg;
    int unsigned ph_cnt;
    logic        last_level;
    logic [63:0] launch_us;
    logic [63:0] ready_us;
    logic [2:0]  frame_pos;
    logic [7:0]  frame_buf [6];

    meas_t       meas_q [$];
    dir_row_t    dir_rows [$];
    int          mismatches = 0;
    int          cycles = 0;
    bit          quiet = 1'b0;
    logic [63:0] clock_us = 64'd0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic meas_t mk_meas(action_t act, logic [7:0] cmd, logic [21:0] pres,
                                      logic [16:0] temp, logic [63:0] rdy,
                                      logic [63:0] done, logic [62:0] delay);
        meas_t m;
        m.action      = act;
        m.command     = cmd;
        m.pressure    = pres;
        m.temperature = temp;
        m.ready_stamp = rdy;
        m.done_stamp  = done;
        m.group_delay = delay;
        return m;
    endfunction

    function automatic bit sequence_step(kind_t kind, logic level, logic [7:0] rx,
                                         logic [63:0] now_us, output meas_t r);
        int unsigned eff;
        int unsigned nxt;
        logic [63:0] praw;
        logic [63:0] traw;
        logic [63:0] pv;
        logic [63:0] tv;
        bit          hit;
        hit = 1'b0;
        r = mk_meas(ACT_START, 8'd0, 22'd0, 17'd0, 64'd0, 64'd0, 63'd0);
        if (kind == KIND_TICK) begin
            eff = 32'(period_reg);
            if (eff == 0)
                eff = 1;
            if (eff > 32'(PHASE_MAX))
                eff = 32'(PHASE_MAX);
            if (ph_cnt == 0) begin
                launch_us = now_us;
                r.action  = ACT_START;
                r.command = cmd_reg;
                hit = 1'b1;
            end else if (!last_level && level) begin
                ready_us = now_us;
                r.action = ACT_READ;
                hit = 1'b1;
            end
            last_level = level;
            nxt = ph_cnt + 1;
            if (nxt >= eff)
                nxt = 0;
            ph_cnt = nxt;
        end else if (frame_pos < 3'd6) begin
            frame_buf[frame_pos] = rx;
            frame_pos = frame_pos + 3'd1;
        end else begin
            frame_pos = 3'd0;
            if (frame_buf[0] == STATUS_OK) begin
                praw = {40'd0, frame_buf[1], frame_buf[2], frame_buf[3]};
                traw = {40'd0, frame_buf[4], frame_buf[5], rx};
                pv = ((praw * 64'd6250) >> 16) - 64'd160000;
                tv = ((traw * 64'd125) >> 16) + 64'd59686;
                r.action      = ACT_MEAS;
                r.pressure    = pv[21:0];
                r.temperature = tv[16:0];
                r.ready_stamp = ready_us;
                r.done_stamp  = now_us;
                pv = ready_us - launch_us;
                r.group_delay = pv[63:1];
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    task automatic check_field(string what, logic [63:0] got, logic [63:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    always @(negedge aclk) begin : result_check
        meas_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (meas_q.size() == 0) begin
                report_mismatch("result with none pending", 64'(m_tuser), 64'd0);
            end else begin
                e = meas_q.pop_front();
                check_field("action", 64'(m_tuser), 64'(e.action));
                check_field("command_out", 64'(m_tdata[7:0]), 64'(e.command));
                check_field("pressure", 64'(m_tdata[29:8]), 64'(e.pressure));
                check_field("temperature", 64'(m_tdata[46:30]), 64'(e.temperature));
                check_field("ready_stamp", m_tdata[110:47], e.ready_stamp);
                check_field("done_stamp", m_tdata[174:111], e.done_stamp);
                check_field("group_delay", 64'(m_tdata[237:175]), 64'(e.group_delay));
            end
        end
    end

    // result side backpressure
    initial begin
        m_tready = 1'b0;
        @(posedge aclk);
        forever begin
            if (!quiet && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
    end

    // returns at the edge where the request is taken
    task automatic drive_item(kind_t kind, logic level, logic [7:0] rx, logic [63:0] now_us);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {7'd0, now_us, rx, level};
        do
            @(negedge aclk);
        while (!s_tready);
        @(posedge aclk);
    endtask

    task automatic apply_item(kind_t kind, logic level, logic [7:0] rx);
        meas_t r;
        if ($urandom_range(0, 19) == 0)
            clock_us = {$urandom, $urandom};
        else
            clock_us = clock_us + 64'($urandom_range(1, 5000));
        drive_item(kind, level, rx, clock_us);
        if (sequence_step(kind, level, rx, clock_us, r))
            meas_q.push_back(r);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (meas_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_index_t sel, logic [10:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        if (sel == CFG_COMMAND_BYTE)
            cmd_reg = val[7:0];
        else
            period_reg = val;
        @(posedge aclk);
    endtask

    function automatic dir_row_t item_row(kind_t kind, logic level, logic [7:0] rx,
                                          logic [63:0] now_us, bit typed, bit has_res,
                                          meas_t res);
        dir_row_t d;
        d.is_cfg  = 1'b0;
        d.reg_sel = CFG_COMMAND_BYTE;
        d.reg_val = 11'd0;
        d.kind    = kind;
        d.level   = level;
        d.rx      = rx;
        d.now_us  = now_us;
        d.typed   = typed;
        d.has_res = has_res;
        d.res     = res;
        return d;
    endfunction

    function automatic dir_row_t cfg_row(cfg_index_t sel, logic [10:0] val);
        dir_row_t d;
        d = item_row(KIND_TICK, 1'b0, 8'd0, 64'd0, 1'b0, 1'b0, '0);
        d.is_cfg  = 1'b1;
        d.reg_sel = sel;
        d.reg_val = val;
        return d;
    endfunction

    task automatic build_directed();
        meas_t none;
        none = '0;
        dir_rows.push_back(item_row(KIND_TICK, 1'b0, 8'h00, 64'd0, 1, 1,
            mk_meas(ACT_START, 8'd170, 22'd0, 17'd0, 64'd0, 64'd0, 63'd0)));
        dir_rows.push_back(item_row(KIND_TICK, 1'b1, 8'h00, 64'd100, 1, 1,
            mk_meas(ACT_READ, 8'd0, 22'd0, 17'd0, 64'd0, 64'd0, 63'd0)));
        // full scale frame
        dir_rows.push_back(item_row(KIND_BYTE, 1'b0, STATUS_OK, 64'd400, 1, 0, none));
        repeat (5) dir_rows.push_back(item_row(KIND_BYTE, 1'b1, 8'hFF, 64'd401, 1, 0, none));
        dir_rows.push_back(item_row(KIND_BYTE, 1'b0, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 1, 1,
            mk_meas(ACT_MEAS, 8'd0, 22'd1439999, 17'd91685, 64'd100,
                    64'hFFFF_FFFF_FFFF_FFFF, 63'd50)));
        // zero scale frame
        dir_rows.push_back(item_row(KIND_BYTE, 1'b0, STATUS_OK, 64'd450, 1, 0, none));
        repeat (5) dir_rows.push_back(item_row(KIND_BYTE, 1'b0, 8'h00, 64'd460, 1, 0, none));
        dir_rows.push_back(item_row(KIND_BYTE, 1'b0, 8'h00, 64'd500, 1, 1,
            mk_meas(ACT_MEAS, 8'd0, -22'sd160000, 17'd59686, 64'd100, 64'd500, 63'd50)));
        // bad status drops the frame
        dir_rows.push_back(item_row(KIND_BYTE, 1'b0, 8'h41, 64'd510, 1, 0, none));
        dir_rows.push_back(item_row(KIND_BYTE, 1'b0, 8'h12, 64'd511, 1, 0, none));
        dir_rows.push_back(item_row(KIND_BYTE, 1'b0, 8'h34, 64'd512, 1, 0, none));
        dir_rows.push_back(item_row(KIND_BYTE, 1'b0, 8'h56, 64'd513, 1, 0, none));
        dir_rows.push_back(item_row(KIND_BYTE, 1'b0, 8'h78, 64'd514, 1, 0, none));
        dir_rows.push_back(item_row(KIND_BYTE, 1'b0, 8'h9A, 64'd515, 1, 0, none));
        dir_rows.push_back(item_row(KIND_BYTE, 1'b0, 8'hBC, 64'd516, 1, 0, none));
        // zero period starts on every tick, the start wins over a ready edge
        // first tick still runs at phase 2 with the line already high
        dir_rows.push_back(cfg_row(CFG_COMMAND_BYTE, 11'd255));
        dir_rows.push_back(cfg_row(CFG_START_PERIOD, 11'd0));
        dir_rows.push_back(item_row(KIND_TICK, 1'b1, 8'h00, 64'd600, 1, 0, none));
        dir_rows.push_back(item_row(KIND_TICK, 1'b0, 8'h00, 64'd700, 1, 1,
            mk_meas(ACT_START, 8'd255, 22'd0, 17'd0, 64'd0, 64'd0, 63'd0)));
        dir_rows.push_back(item_row(KIND_TICK, 1'b1, 8'h00, 64'd800, 1, 1,
            mk_meas(ACT_START, 8'd255, 22'd0, 17'd0, 64'd0, 64'd0, 63'd0)));
        // launch after ready, delay wraps
        dir_rows.push_back(item_row(KIND_BYTE, 1'b0, STATUS_OK, 64'd900, 0, 0, none));
        dir_rows.push_back(item_row(KIND_BYTE, 1'b0, 8'h80, 64'd901, 0, 0, none));
        dir_rows.push_back(item_row(KIND_BYTE, 1'b0, 8'h00, 64'd902, 0, 0, none));
        dir_rows.push_back(item_row(KIND_BYTE, 1'b0, 8'h01, 64'd903, 0, 0, none));
        dir_rows.push_back(item_row(KIND_BYTE, 1'b0, 8'h7F, 64'd904, 0, 0, none));
        dir_rows.push_back(item_row(KIND_BYTE, 1'b0, 8'hFF, 64'd905, 0, 0, none));
        dir_rows.push_back(item_row(KIND_BYTE, 1'b0, 8'h00, 64'd906, 0, 0, none));
    endtask

    task automatic run_directed();
        meas_t r;
        bit    hit;
        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg) begin
                wait_drained();
                write_reg(dir_rows[i].reg_sel, dir_rows[i].reg_val);
            end else begin
                drive_item(dir_rows[i].kind, dir_rows[i].level, dir_rows[i].rx,
                           dir_rows[i].now_us);
                hit = sequence_step(dir_rows[i].kind, dir_rows[i].level, dir_rows[i].rx,
                                    dir_rows[i].now_us, r);
                if (dir_rows[i].typed) begin
                    if (dir_rows[i].has_res)
                        meas_q.push_back(dir_rows[i].res);
                end else if (hit) begin
                    meas_q.push_back(r);
                end
                clock_us = dir_rows[i].now_us;
            end
        end
    endtask

    // one conversion: fill any partial frame, idle ticks, a ready edge, up to two more ticks, then the 7-byte frame
    task automatic conversion_cycle(ref int count);
        int unsigned fill;
        logic [7:0]  status;
        if (frame_pos != 3'd0) begin
            fill = 7 - 32'(frame_pos);
            repeat (fill) begin
                apply_item(KIND_BYTE, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
                count++;
            end
        end
        repeat ($urandom_range(1, 3)) begin
            apply_item(KIND_TICK, 1'b0, 8'($urandom_range(0, 255)));
            count++;
        end
        apply_item(KIND_TICK, 1'b1, 8'($urandom_range(0, 255)));
        count++;
        repeat ($urandom_range(0, 2)) begin
            apply_item(KIND_TICK, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            count++;
        end
        status = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : STATUS_OK;
        apply_item(KIND_BYTE, 1'($urandom_range(0, 1)), status);
        count++;
        repeat (6) begin
            apply_item(KIND_BYTE, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            count++;
        end
    endtask

    task automatic run_phase(logic [7:0] cmd, logic [10:0] period, int n_items, bit hold_mid);
        int  count;
        bit  held;
        wait_drained();
        write_reg(CFG_COMMAND_BYTE, {3'd0, cmd});
        write_reg(CFG_START_PERIOD, period);
        count = 0;
        held = 1'b0;
        while (count < n_items) begin
            if (hold_mid && !held && count >= n_items / 2) begin
                wait_drained();
                held = 1'b1;
            end
            if ($urandom_range(0, 9) < 7) begin
                conversion_cycle(count);
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    apply_item(kind_t'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                               8'($urandom_range(0, 255)));
                    count++;
                end
            end
        end
    endtask

    initial begin
        logic [10:0] periods [11];
        logic [7:0]  cmds [11];
        aresetn    = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_COMMAND_BYTE;
        cfg_data   = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = KIND_TICK;
        cmd_reg    = COMMAND_RESET;
        period_reg = PERIOD_RESET;
        ph_cnt     = 0;
        last_level = 1'b0;
        launch_us  = 64'd0;
        ready_us   = 64'd0;
        frame_pos  = 3'd0;
        periods = '{11'd1, 11'd2047, 11'd1024, 11'd0, 11'd3, 11'd5,
                    11'd2, 11'd16, 11'd1025, 11'd7, 11'd1};
        cmds    = '{8'd0, 8'd255, 8'h5A, 8'hA5, 8'd1, 8'd128,
                    8'd0, 8'd255, 8'd17, 8'd200, 8'd99};
        build_directed();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        run_directed();
        for (int p = 0; p < 11; p++) begin
            if (p == 10)
                quiet = 1'b1;
            if (p == 9)
                periods[p] = 11'($urandom_range(1, 40));
            run_phase(cmds[p], periods[p], 150, p == 4);
        end
        wait_drained();
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
